/* rtl/page_free_list_allocator_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef PAGE_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// Checked only outside reset.
`define PFLA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pfla check failed");

// Checked at every edge, reset included.
`define PFLA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pfla reset check failed");

`endif

/* rtl/pfla_pkg.sv */
`timescale 1ns / 1ps
package pfla_pkg;

    localparam int MAX_PAGES  = 65536;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PN_W       = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W      = $clog2(MAX_PAGES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CFG_AW     = 3;

    // request codes
    localparam logic [1:0] REQ_FREE  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ADDR = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // register indexes (taken from paddr[2])
    localparam logic REG_KERNEL_END = 1'b0;
    localparam logic REG_PHYS_TOP   = 1'b1;

    localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'd1048576;
    localparam logic [ADDR_W-1:0] PHYS_TOP_RST   = 32'd234881024;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_addr;
        logic [1:0]        status;
    } t_rsp;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [PN_W-1:0] page;
    } t_stk_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_stat;

endpackage

/* rtl/pfla_stack.sv */
`timescale 1ns / 1ps
module pfla_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfla_pkg::t_stk_cmd            i_cmd,
    output pfla_pkg::t_stk_stat           o_stat,
    output logic [pfla_pkg::PN_W-1:0]     o_rd_page
);

    logic [pfla_pkg::PN_W-1:0]  r_mem [pfla_pkg::MAX_PAGES];
    logic [pfla_pkg::CNT_W-1:0] r_count;
    logic [pfla_pkg::CNT_W-1:0] n_count;
    logic [pfla_pkg::CNT_W-1:0] w_top;
    logic [pfla_pkg::PN_W-1:0]  r_rd_page;

    assign w_top = r_count - pfla_pkg::CNT_W'(1);

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + pfla_pkg::CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // controller never pushes when full nor pops when empty
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[pfla_pkg::IDX_W-1:0]] <= i_cmd.page;
        end
        if (i_cmd.pop) begin
            r_rd_page <= r_mem[w_top[pfla_pkg::IDX_W-1:0]];
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = r_count[pfla_pkg::IDX_W];
    assign o_rd_page    = r_rd_page;

endmodule

/* rtl/page_free_list_allocator_unit.sv */
`timescale 1ns / 1ps
// LIFO pool of free physical pages, state held in a single-port page stack.
// Input channel (i_in_valid / o_in_stall, payload i_in_data) takes free,
// alloc or init requests; each gives exactly one result item on the output
// channel (o_out_valid / i_out_stall, payload o_out_data). One item is in
// work at a time.
// The result is registered after accept: a free from the execute state, an
// alloc from the pop state that follows the synchronous stack read, an init
// once the init state has pushed its N pages, one stack write per cycle.
// A new request is taken in the cycle after the previous result is
// registered, so a result waiting at a stalled output does not block intake;
// the next result waits only if the output register is still occupied.
// kernel_end and phys_top are written over the APB port; write them only
// while the block is idle.
// Reset (synchronous, active low) empties the pool, clears the output and
// restores the register defaults. Stack contents are not cleared: only
// entries below the fill count are ever read.
module page_free_list_allocator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pfla_pkg::t_req                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pfla_pkg::t_rsp                      o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pfla_pkg::CFG_AW-1:0]         paddr,
    input  logic [pfla_pkg::ADDR_W-1:0]         pwdata,
    output logic [pfla_pkg::ADDR_W-1:0]         prdata,
    output logic                                pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_INIT = 2'd3;

    localparam int PG_W = pfla_pkg::PN_W + 1;

    logic [1:0]                  r_state, n_state;
    pfla_pkg::t_req              r_req, n_req;
    logic [PG_W-1:0]             r_page, n_page;
    logic [pfla_pkg::ADDR_W-1:0] r_kernel_end, r_phys_top;
    logic                        r_out_valid, n_out_valid;
    pfla_pkg::t_rsp              r_out, n_out;

    pfla_pkg::t_stk_cmd          w_cmd;
    pfla_pkg::t_stk_stat         w_stat;
    logic [pfla_pkg::PN_W-1:0]   w_rd_page;

    logic                        w_slot_free;
    logic                        w_fin;
    pfla_pkg::t_rsp              w_fin_data;
    logic                        w_addr_ok;
    logic [pfla_pkg::ADDR_W:0]   w_round;
    logic [PG_W-1:0]             w_start;
    logic [PG_W-1:0]             w_top_pg;
    logic                        w_cfg_wr;

    pfla_stack u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_rd_page (w_rd_page)
    );

    assign w_slot_free = !r_out_valid || !i_out_stall;

    assign w_addr_ok = (r_req.free_addr[pfla_pkg::PAGE_SHIFT-1:0] == '0)
                    && (r_req.free_addr >= r_kernel_end)
                    && (r_req.free_addr <  r_phys_top);

    // first whole page at or above kernel_end; may reach 2^PN_W
    assign w_round  = {1'b0, r_kernel_end}
                    + (pfla_pkg::ADDR_W + 1)'(pfla_pkg::PAGE_BYTES - 1);
    assign w_start  = w_round[pfla_pkg::ADDR_W:pfla_pkg::PAGE_SHIFT];
    assign w_top_pg = {1'b0, r_phys_top[pfla_pkg::ADDR_W-1:pfla_pkg::PAGE_SHIFT]};

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_page     = r_page;
        w_cmd      = '0;
        w_fin      = 1'b0;
        w_fin_data = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    case (r_req.req_type)
                        pfla_pkg::REQ_FREE: begin
                            w_fin   = 1'b1;
                            n_state = S_IDLE;
                            if (!w_addr_ok) begin
                                w_fin_data.status = pfla_pkg::ST_BAD_ADDR;
                            end else if (w_stat.full) begin
                                w_fin_data.status = pfla_pkg::ST_OVERFLOW;
                            end else begin
                                w_cmd.push = 1'b1;
                                w_cmd.page = r_req.free_addr[pfla_pkg::ADDR_W-1:
                                                             pfla_pkg::PAGE_SHIFT];
                                w_fin_data.status = pfla_pkg::ST_OK;
                            end
                        end
                        pfla_pkg::REQ_ALLOC: begin
                            if (w_stat.empty) begin
                                w_fin             = 1'b1;
                                w_fin_data.status = pfla_pkg::ST_EMPTY;
                                n_state           = S_IDLE;
                            end else begin
                                w_cmd.pop = 1'b1;
                                n_state   = S_POP;
                            end
                        end
                        pfla_pkg::REQ_INIT: begin
                            n_page  = w_start;
                            n_state = S_INIT;
                        end
                        default: begin
                            w_fin             = 1'b1;
                            w_fin_data.status = pfla_pkg::ST_OK;
                            n_state           = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (w_slot_free) begin
                    w_fin                 = 1'b1;
                    w_fin_data.alloc_addr = {w_rd_page, {pfla_pkg::PAGE_SHIFT{1'b0}}};
                    w_fin_data.status     = pfla_pkg::ST_OK;
                    n_state               = S_IDLE;
                end
            end
            S_INIT: begin
                // range done first, so an exact fit still reports ok
                if (r_page >= w_top_pg) begin
                    if (w_slot_free) begin
                        w_fin             = 1'b1;
                        w_fin_data.status = pfla_pkg::ST_OK;
                        n_state           = S_IDLE;
                    end
                end else if (w_stat.full) begin
                    if (w_slot_free) begin
                        w_fin             = 1'b1;
                        w_fin_data.status = pfla_pkg::ST_OVERFLOW;
                        n_state           = S_IDLE;
                    end
                end else begin
                    w_cmd.push = 1'b1;
                    w_cmd.page = r_page[pfla_pkg::PN_W-1:0];
                    n_page     = r_page + PG_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_fin) begin
            n_out_valid = 1'b1;
            n_out       = w_fin_data;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_page <= n_page;
        r_out  <= n_out;
    end

    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_end <= pfla_pkg::KERNEL_END_RST;
            r_phys_top   <= pfla_pkg::PHYS_TOP_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == pfla_pkg::REG_KERNEL_END) begin
                r_kernel_end <= pwdata;
            end else begin
                r_phys_top <= pwdata;
            end
        end
    end

    assign prdata      = (paddr[2] == pfla_pkg::REG_PHYS_TOP) ? r_phys_top : r_kernel_end;
    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/pfla_chk.sv */
`timescale 1ns / 1ps
`include "page_free_list_allocator_unit_defines.svh"
module pfla_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  pfla_pkg::t_rsp                      o_out_data
);

    `PFLA_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_out_valid)

    // one item in work: intake closes right after an accept
    `PFLA_ASSERT(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall)

    // a nonzero address only comes from a good alloc, always page aligned
    `PFLA_ASSERT(a_alloc_addr_ok,
        (o_out_valid && (o_out_data.alloc_addr != '0)) |->
        ((o_out_data.status == pfla_pkg::ST_OK) &&
         (o_out_data.alloc_addr[pfla_pkg::PAGE_SHIFT-1:0] == '0)))

    `PFLA_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_out_data)))

endmodule

bind page_free_list_allocator_unit pfla_chk u_pfla_chk (.*);

/* sim/page_free_list_allocator_unit_tb.sv */
`timescale 1ns / 1ps
module page_free_list_allocator_unit_tb;
    import pfla_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         LIMIT_CYCLES = 1000000;
    localparam int         HOLD_CYCLES  = 400;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_req                  i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_rsp                  o_out_data;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_AW-1:0]     paddr       = '0;
    logic [ADDR_W-1:0]     pwdata      = '0;
    logic [ADDR_W-1:0]     prdata;
    logic                  pready;

    // mirror of the pool and the registers
    logic [PN_W-1:0]       pool_pages [MAX_PAGES];
    int                    pool_fill      = 0;
    logic [ADDR_W-1:0]     cfg_kernel_end = KERNEL_END_RST;
    logic [ADDR_W-1:0]     cfg_phys_top   = PHYS_TOP_RST;

    t_rsp                  rsp_due_q [$];
    t_rsp                  rsp_want;
    int                    fail_count  = 0;
    int                    cycle_count = 0;
    int                    send_idle_pct = 0;
    int                    stall_pct     = 0;
    int                    hold_req  = 0;
    int                    hold_seen = 0;
    int                    hold_left = 0;

    page_free_list_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output stall: random, or a long hold-off when the test asks for one
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rsp_due_q.size() == 0) begin
                $error("unexpected result item: alloc_addr %h status %0d",
                       o_out_data.alloc_addr, o_out_data.status);
                fail_count++;
            end else begin
                rsp_want = rsp_due_q.pop_front();
                if (o_out_data.alloc_addr !== rsp_want.alloc_addr) begin
                    $error("alloc_addr: expected %h, actual %h",
                           rsp_want.alloc_addr, o_out_data.alloc_addr);
                    fail_count++;
                end
                if (o_out_data.status !== rsp_want.status) begin
                    $error("status: expected %0d, actual %0d",
                           rsp_want.status, o_out_data.status);
                    fail_count++;
                end
            end
        end
    end

    function automatic t_rsp pool_serve(t_req r);
        t_rsp              rsp;
        longint unsigned   first;
        longint unsigned   top;
        longint unsigned   n;
        longint unsigned   room;
        longint unsigned   k;
        logic [PN_W-1:0]   pn;
        rsp.alloc_addr = '0;
        rsp.status     = ST_OK;
        case (r.req_type)
            REQ_FREE: begin
                if (r.free_addr[PAGE_SHIFT-1:0] != 0 || r.free_addr < cfg_kernel_end ||
                    r.free_addr >= cfg_phys_top) begin
                    rsp.status = ST_BAD_ADDR;
                end else if (pool_fill >= MAX_PAGES) begin
                    rsp.status = ST_OVERFLOW;
                end else begin
                    pool_pages[pool_fill] = r.free_addr[ADDR_W-1:PAGE_SHIFT];
                    pool_fill++;
                end
            end
            REQ_ALLOC: begin
                if (pool_fill == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    pool_fill--;
                    rsp.alloc_addr = {pool_pages[pool_fill], {PAGE_SHIFT{1'b0}}};
                end
            end
            REQ_INIT: begin
                // start may round past 2^32; kept in 64 bits
                first = ((longint'(cfg_kernel_end) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
                top   = longint'(cfg_phys_top);
                if (first + PAGE_BYTES <= top) begin
                    n    = (top - first) / PAGE_BYTES;
                    room = longint'(MAX_PAGES - pool_fill);
                    if (n > room) begin
                        n          = room;
                        rsp.status = ST_OVERFLOW;
                    end
                    for (k = 0; k < n; k++) begin
                        pn = PN_W'(first / PAGE_BYTES + k);
                        pool_pages[pool_fill] = pn;
                        pool_fill++;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic offer_request(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
        t_req item;
        item.req_type  = kind;
        item.free_addr = addr;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        rsp_due_q.push_back(pool_serve(item));
    endtask

    // wait until every result has been taken and the block is idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (rsp_due_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic sel, input logic [ADDR_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_KERNEL_END)
            cfg_kernel_end = value;
        else
            cfg_phys_top = value;
    endtask

    task automatic set_window(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
        apb_write(REG_KERNEL_END, lo);
        apb_write(REG_PHYS_TOP, hi);
    endtask

    // small random window so inits stay short and the pool drains now and then
    task automatic pick_window();
        logic [ADDR_W-1:0] ke;
        longint unsigned   hi;
        ke = $urandom_range(32'hFFF0_0000, 0);
        if ($urandom_range(1))
            ke[PAGE_SHIFT-1:0] = '0;
        hi = ((longint'(ke) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES
             + longint'($urandom_range(12)) * PAGE_BYTES;
        if ($urandom_range(1))
            hi = hi + $urandom_range(PAGE_BYTES - 1);
        set_window(ke, 32'(hi));
    endtask

    task automatic run_traffic(input int count);
        longint unsigned   lo;
        int                npages;
        int                pick;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        repeat (count) begin
            lo = ((longint'(cfg_kernel_end) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
            npages = (longint'(cfg_phys_top) > lo) ? int'((cfg_phys_top - lo) / PAGE_BYTES) : 0;
            pick = $urandom_range(99);
            addr = $urandom;
            if (npages > 0 && pick >= 50 && pick < 92)
                addr = 32'(lo + longint'($urandom_range(npages - 1)) * PAGE_BYTES);
            if (pick < 50) begin
                kind = REQ_ALLOC;
            end else if (pick < 75) begin
                kind = REQ_FREE;
            end else if (pick < 79) begin
                kind = REQ_INIT;
            end else if (pick < 92) begin
                kind = REQ_FREE;
                case ($urandom_range(3))
                    0: addr[PAGE_SHIFT-1:0] =
                           PAGE_SHIFT'($urandom_range(PAGE_BYTES - 1, 1));
                    1: begin
                        if (cfg_kernel_end != 0)
                            addr = (cfg_kernel_end - 1) & ~(PAGE_BYTES - 1);
                        else
                            addr[PAGE_SHIFT-1:0] =
                                PAGE_SHIFT'($urandom_range(PAGE_BYTES - 1, 1));
                    end
                    2: addr = cfg_phys_top;
                    default: addr = $urandom;
                endcase
            end else begin
                kind = REQ_UNUSED;
            end
            offer_request(kind, addr);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    task automatic test_defaults_after_reset();
        offer_request(REQ_ALLOC, 32'h0);
        offer_request(REQ_UNUSED, 32'hFFFF_FFFF);
        offer_request(REQ_FREE, KERNEL_END_RST);
        offer_request(REQ_FREE, KERNEL_END_RST + 1);
        offer_request(REQ_FREE, KERNEL_END_RST - PAGE_BYTES);
        offer_request(REQ_FREE, PHYS_TOP_RST);
        offer_request(REQ_FREE, PHYS_TOP_RST - PAGE_BYTES);
        repeat (3) offer_request(REQ_ALLOC, 32'h0);
        settle();
    endtask

    task automatic test_register_extremes();
        set_window(32'h0, 32'hFFFF_FFFF);
        offer_request(REQ_FREE, 32'h0);
        offer_request(REQ_FREE, 32'hFFFF_F000);
        offer_request(REQ_FREE, 32'hFFFF_FFFF);
        offer_request(REQ_ALLOC, 32'h0);
        offer_request(REQ_ALLOC, 32'hFFFF_FFFF);
        settle();
        // rounding up passes 2^32: empty range
        apb_write(REG_KERNEL_END, 32'hFFFF_F001);
        offer_request(REQ_INIT, 32'h0);
        settle();
        // one page would end past the top: empty range
        apb_write(REG_KERNEL_END, 32'hFFFF_F000);
        offer_request(REQ_INIT, 32'h0);
        settle();
        set_window(32'hFFFF_FFFF, 32'h0);
        offer_request(REQ_FREE, 32'h0);
        settle();
    endtask

    task automatic test_init_on_top_of_pool();
        set_window(32'h0000_3001, 32'h0000_A800);
        offer_request(REQ_FREE, 32'h0000_5000);
        offer_request(REQ_INIT, 32'h0);
        repeat (8) offer_request(REQ_ALLOC, 32'h0);
        settle();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        set_idling(send_pct, recv_pct);
        repeat (4) begin
            pick_window();
            run_traffic(64);
            settle();
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        set_idling(0, 0);
        pick_window();
        hold_req = hold_req + 1;
        run_traffic(24);
        settle();
    endtask

    task automatic test_pool_overflow();
        set_idling(22, 22);
        set_window(32'h0, 32'hFFFF_FFFF);
        offer_request(REQ_INIT, 32'h0);
        offer_request(REQ_FREE, 32'h0000_7000);
        repeat (3) offer_request(REQ_ALLOC, 32'h0);
        offer_request(REQ_INIT, 32'h0);
        offer_request(REQ_ALLOC, 32'h0);
        settle();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults_after_reset();
        test_register_extremes();
        test_init_on_top_of_pool();
        test_random_traffic(0, 0);
        test_random_traffic(45, 0);
        test_random_traffic(0, 45);
        test_random_traffic(22, 22);
        test_backpressure();
        test_pool_overflow();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
